// ----- rtl/envelope_follower_compressor_macros.svh -----
// Assertion macros used by the envelope follower compressor datapath.
`ifndef ENVELOPE_FOLLOWER_COMPRESSOR_MACROS_SVH
`define ENVELOPE_FOLLOWER_COMPRESSOR_MACROS_SVH
`ifndef ASSERT_OFF
// Concurrent assertion on an explicit clock and active-low reset.
`define EFC_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// Concurrent assertion on the module's clk and rst_n.
`define EFC_ASSERT(lbl, prop, msg) `EFC_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define EFC_ASSERT_CLK(lbl, clk_s, rst_s, prop, msg)
`define EFC_ASSERT(lbl, prop, msg)
`endif
`endif

// ----- rtl/efc_pkg.sv -----
// Types and constants of the envelope follower compressor.
package efc_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned COEFF_W  = 24;
  localparam int unsigned RATIO_W  = 16;
  localparam int unsigned PROD_W   = 48;
  localparam int unsigned DIV_STEPS = 24;
  localparam int unsigned CNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned CFG_AW   = 4;
  localparam int unsigned CFG_DW   = 32;

  localparam logic [COEFF_W-1:0]  ATTACK_RST    = 24'd16707457;
  localparam logic [COEFF_W-1:0]  RELEASE_RST   = 24'd16774886;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 24'd3774874;
  localparam logic [RATIO_W-1:0]  RATIO_RST     = 16'd18725;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 24'h800000;

  typedef enum logic [1:0] {
    REG_ATTACK    = 2'd0,
    REG_RELEASE   = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_RATIO     = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEL,
    S_MUL_ENV,
    S_MUL_MAG,
    S_ENV,
    S_CMP,
    S_MUL_RATIO,
    S_TGT,
    S_MUL_TGT,
    S_DIV_INIT,
    S_DIV,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MUL_ENV,
    MUL_MAG,
    MUL_RATIO,
    MUL_TGT
  } mul_sel_t;

  typedef struct packed {
    logic [COEFF_W-1:0]  attack_coeff;
    logic [COEFF_W-1:0]  release_coeff;
    logic [SAMPLE_W-1:0] threshold_level;
    logic [RATIO_W-1:0]  ratio_reciprocal;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     sel_coeff;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     env_load;
    logic     cmp;
    logic     tgt_load;
    logic     div_init;
    logic     div_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic comp;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/efc_regs.sv -----
// Configuration register file behind the APB-style port.
module efc_regs
  import efc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coeff     <= ATTACK_RST;
      cfg_r.release_coeff    <= RELEASE_RST;
      cfg_r.threshold_level  <= THRESHOLD_RST;
      cfg_r.ratio_reciprocal <= RATIO_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ATTACK:    cfg_r.attack_coeff     <= pwdata[COEFF_W-1:0];
        REG_RELEASE:   cfg_r.release_coeff    <= pwdata[COEFF_W-1:0];
        REG_THRESHOLD: cfg_r.threshold_level  <= pwdata[SAMPLE_W-1:0];
        REG_RATIO:     cfg_r.ratio_reciprocal <= pwdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ATTACK:    prdata = {{(CFG_DW-COEFF_W){1'b0}}, cfg_r.attack_coeff};
      REG_RELEASE:   prdata = {{(CFG_DW-COEFF_W){1'b0}}, cfg_r.release_coeff};
      REG_THRESHOLD: prdata = {{(CFG_DW-SAMPLE_W){1'b0}}, cfg_r.threshold_level};
      REG_RATIO:     prdata = {{(CFG_DW-RATIO_W){1'b0}}, cfg_r.ratio_reciprocal};
      default:       prdata = '0;
    endcase
  end

endmodule

// ----- rtl/efc_ctrl.sv -----
// Sequencer that steps the datapath through one sample.
module efc_ctrl
  import efc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = MUL_ENV;
    in_stall    = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        cmd.sel_coeff = 1'b1;
        state_nxt     = S_MUL_ENV;
      end
      S_MUL_ENV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_ENV;
        state_nxt   = S_MUL_MAG;
      end
      S_MUL_MAG: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_MAG;
        cmd.acc_load = 1'b1;
        state_nxt    = S_ENV;
      end
      S_ENV: begin
        cmd.env_load = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_MUL_RATIO;
      end
      S_MUL_RATIO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_RATIO;
        state_nxt   = stat.comp ? S_TGT : S_OUT;
      end
      S_TGT: begin
        cmd.tgt_load = 1'b1;
        state_nxt    = S_MUL_TGT;
      end
      S_MUL_TGT: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TGT;
        state_nxt   = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/efc_dp.sv -----
// Envelope, gain target, divider and output register.
module efc_dp
  import efc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_compressing
);

  `include "envelope_follower_compressor_macros.svh"

  logic [SAMPLE_W-1:0] raw_r, mag_r, env_r, diff_r, tgt_r, rem_r, dvd_r;
  logic [COEFF_W-1:0]  c_r;
  logic                neg_r, comp_r;
  logic [PROD_W-1:0]   prod_r, acc_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_sample_r;
  logic                out_comp_r;

  logic [COEFF_W:0]    mul_a;
  logic [SAMPLE_W-1:0] mul_b;
  logic [PROD_W:0]     mul_p;
  logic [SAMPLE_W-1:0] in_mag;
  logic [PROD_W-1:0]   env_sum;
  logic [SAMPLE_W:0]   shifted;
  logic                ge;
  logic [SAMPLE_W:0]   trial;

  assign in_mag = in_sample_in[SAMPLE_W-1] ? SAMPLE_W'(-in_sample_in) : in_sample_in;

  always_comb begin
    case (cmd.mul_sel)
      MUL_ENV: begin
        mul_a = {1'b0, c_r};
        mul_b = env_r;
      end
      MUL_MAG: begin
        mul_a = {1'b1, {COEFF_W{1'b0}}} - {1'b0, c_r};
        mul_b = mag_r;
      end
      MUL_RATIO: begin
        mul_a = {{(COEFF_W+1-RATIO_W){1'b0}}, cfg.ratio_reciprocal};
        mul_b = diff_r;
      end
      default: begin
        mul_a = {1'b0, tgt_r};
        mul_b = mag_r;
      end
    endcase
  end

  assign mul_p   = mul_a * mul_b;
  assign env_sum = acc_r + prod_r;
  assign shifted = {rem_r, dvd_r[SAMPLE_W-1]};
  assign ge      = shifted >= {1'b0, env_r};
  assign trial   = shifted - {1'b0, env_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      env_r <= '0;
    end else if (cmd.env_load) begin
      env_r <= env_sum[PROD_W-1:SAMPLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r <= in_sample_in;
      neg_r <= in_sample_in[SAMPLE_W-1];
      mag_r <= in_mag;
    end
    if (cmd.sel_coeff) begin
      c_r <= (mag_r > env_r) ? cfg.attack_coeff : cfg.release_coeff;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p[PROD_W-1:0];
    end
    if (cmd.acc_load) begin
      // round the weighted mean to nearest
      acc_r <= prod_r + {{(PROD_W-SAMPLE_W){1'b0}}, FULL_SCALE};
    end
    if (cmd.cmp) begin
      comp_r <= env_r > cfg.threshold_level;
      diff_r <= env_r - cfg.threshold_level;
    end
    if (cmd.tgt_load) begin
      tgt_r <= cfg.threshold_level + prod_r[39:16] + {{(SAMPLE_W-1){1'b0}}, prod_r[15]};
    end
    if (cmd.div_init) begin
      rem_r <= prod_r[PROD_W-1:SAMPLE_W];
      dvd_r <= prod_r[SAMPLE_W-1:0];
    end else if (cmd.div_step) begin
      // restoring step: quotient bits shift in where dividend bits leave
      rem_r <= ge ? trial[SAMPLE_W-1:0] : shifted[SAMPLE_W-1:0];
      dvd_r <= {dvd_r[SAMPLE_W-2:0], ge};
    end
    if (cmd.out_load) begin
      out_comp_r <= comp_r;
      if (comp_r) begin
        out_sample_r <= neg_r ? SAMPLE_W'(-dvd_r) : dvd_r;
      end else begin
        out_sample_r <= raw_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.comp       = comp_r;
  assign stat.out_free   = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_compressing = out_comp_r;

  `EFC_ASSERT(a_env_range, env_r <= FULL_SCALE, "envelope above full scale")
  `EFC_ASSERT(a_div_rem, cmd.div_step |-> (rem_r < env_r), "divider remainder not below divisor")
  `EFC_ASSERT(a_gain_le_one, (cmd.out_load && comp_r) |-> (dvd_r <= mag_r), "gain above unity")
  `EFC_ASSERT(a_out_set, cmd.out_load |=> out_valid_r, "result lost at output register")

endmodule

// ----- rtl/envelope_follower_compressor.sv -----
// Top level of the feedforward peak compressor with hard knee.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall   in_sample_in (s24, Q1.23)
//  out_     output     out_valid / out_stall out_sample_out (s24), out_compressing
//  config   APB-style  psel/penable/pwrite   paddr[3:0], pwdata/prdata 32b
//
// A compressed sample goes from transfer to result via nine setup steps
// through the shared 25x24 multiplier, a 24-step restoring divider with one
// quotient bit per cycle, then the output load; below the knee it skips the divide.
// Synchronous active-low reset clears the envelope, the sequencer and the
// output valid, and loads the register defaults. The next sample is taken while
// a result waits; a finished sample holds only while a full output register is stalled.
module envelope_follower_compressor
  import efc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  output logic                       out_compressing,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_AW-1:0]          paddr,
  input  logic [CFG_DW-1:0]          pwdata,
  output logic [CFG_DW-1:0]          prdata,
  output logic                       pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  // Coefficients, knee, ratio; user writes only when no sample in flight; no check.
  efc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer: accept in idle, step the datapath, hold at the output slot.
  efc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: envelope update, gain target, divide, output register.
  efc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_compressing (out_compressing)
  );

endmodule
